FILE: hw/rtl/v4a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4a_pkg: shared types and constants for the vector arithmetic unit
// Operation codes, the control word that travels with each item through the
// pipeline, and the saturation helper.
// ----------------------------------------------------------------------------
package v4a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LANES         = 4;
    localparam int SQRT_STAGES   = 32;
    localparam int QUO_BITS      = 31;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DIV   = 3'd3,
        OP_RDIV  = 3'd4,
        OP_NORM  = 3'd5,
        OP_MAG   = 3'd6
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       err;
        logic       use_div;
        logic       len_sat;
        logic [3:0] neg;
    } ctl_t;

    // Clamp a 33-bit signed value to the signed 32-bit range.
    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? SAT_MIN : SAT_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/v4a_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4a_front: operand stages of the vector arithmetic unit
// Registers the operands, forms squares, products, add/subtract results and
// divider operands, then sums the squares over two stages.
// ----------------------------------------------------------------------------
module v4a_front
    import v4a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int NW        = 32 + FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [2:0]    in_op,
    input  logic [31:0]   in_a [LANES],
    input  logic [31:0]   in_b [LANES],
    input  logic [31:0]   in_s,
    output logic          out_valid,
    output ctl_t          out_ctl,
    output logic [63:0]   out_sum,
    output logic [NW-1:0] out_num [LANES],
    output logic [31:0]   out_den [LANES],
    output logic [31:0]   out_byp [LANES]
);

    localparam logic [63:0] RND = (64'd1 << FRAC_BITS) - 64'd1;

    // Stage 1: operand register
    logic        v1_reg;
    op_t         op1_reg;
    logic [31:0] a1_reg [LANES];
    logic [31:0] b1_reg [LANES];
    logic [31:0] s1_reg;

    // Stage 2: products and divider operands
    logic        v2_reg;
    ctl_t        ctl2_reg;
    logic [63:0] sq2_reg   [LANES];
    logic [63:0] prod2_reg [LANES];
    logic [31:0] byp2_reg  [LANES];
    logic [NW-1:0] num2_reg [LANES];
    logic [31:0] den2_reg  [LANES];

    // Stage 3: partial sums, scale result
    logic        v3_reg;
    ctl_t        ctl3_reg;
    logic [63:0] sum01_reg, sum23_reg;
    logic [31:0] byp3_reg  [LANES];
    logic [NW-1:0] num3_reg [LANES];
    logic [31:0] den3_reg  [LANES];

    // Stage 4: full sum of squares
    logic        v4_reg;
    ctl_t        ctl4_reg;
    logic [63:0] sum4_reg;
    logic [31:0] byp4_reg  [LANES];
    logic [NW-1:0] num4_reg [LANES];
    logic [31:0] den4_reg  [LANES];

    logic [31:0]   mag_a [LANES];
    logic [31:0]   mag_s;
    logic [63:0]   sq_next    [LANES];
    logic [63:0]   prod_next  [LANES];
    logic [31:0]   byp_next   [LANES];
    logic [NW-1:0] num_next   [LANES];
    logic [31:0]   den_next   [LANES];
    ctl_t          ctl_next;
    logic [31:0]   scale_next [LANES];
    logic [64:0]   sum_next;
    ctl_t          ctl4_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg <= op_t'(in_op);
            a1_reg  <= in_a;
            b1_reg  <= in_b;
            s1_reg  <= in_s;
        end
    end

    // Stage 2 logic: magnitudes, one multiplier pair per lane, operand select.
    always_comb begin
        mag_s    = s1_reg[31] ? 32'd0 - s1_reg : s1_reg;
        ctl_next = '{op: op1_reg, err: 1'b0, use_div: 1'b0, len_sat: 1'b0, neg: 4'b0};
        for (int i = 0; i < LANES; i++) begin
            mag_a[i]     = a1_reg[i][31] ? 32'd0 - a1_reg[i] : a1_reg[i];
            sq_next[i]   = mag_a[i] * mag_a[i];
            prod_next[i] = 64'($signed(a1_reg[i]) * $signed(s1_reg));
            byp_next[i]  = '0;
            num_next[i]  = '0;
            den_next[i]  = '0;
        end
        case (op1_reg)
            OP_ADD: begin
                for (int i = 0; i < LANES; i++) begin
                    byp_next[i] = sat33({a1_reg[i][31], a1_reg[i]} + {b1_reg[i][31], b1_reg[i]});
                end
            end
            OP_SUB: begin
                for (int i = 0; i < LANES; i++) begin
                    byp_next[i] = sat33({a1_reg[i][31], a1_reg[i]} - {b1_reg[i][31], b1_reg[i]});
                end
            end
            OP_DIV: begin
                ctl_next.err     = (s1_reg == 32'd0);
                ctl_next.use_div = (s1_reg != 32'd0);
                for (int i = 0; i < LANES; i++) begin
                    num_next[i]     = {mag_a[i], {FRAC_BITS{1'b0}}};
                    den_next[i]     = mag_s;
                    ctl_next.neg[i] = a1_reg[i][31] ^ s1_reg[31];
                end
            end
            OP_RDIV: begin
                ctl_next.err = (a1_reg[0] == 32'd0) || (a1_reg[1] == 32'd0) ||
                               (a1_reg[2] == 32'd0) || (a1_reg[3] == 32'd0);
                ctl_next.use_div = !ctl_next.err;
                for (int i = 0; i < LANES; i++) begin
                    num_next[i]     = {mag_s, {FRAC_BITS{1'b0}}};
                    den_next[i]     = mag_a[i];
                    ctl_next.neg[i] = a1_reg[i][31] ^ s1_reg[31];
                end
            end
            OP_NORM: begin
                ctl_next.use_div = 1'b1;
                for (int i = 0; i < LANES; i++) begin
                    num_next[i]     = {mag_a[i], {FRAC_BITS{1'b0}}};
                    ctl_next.neg[i] = a1_reg[i][31];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl2_reg  <= ctl_next;
            sq2_reg   <= sq_next;
            prod2_reg <= prod_next;
            byp2_reg  <= byp_next;
            num2_reg  <= num_next;
            den2_reg  <= den_next;
        end
    end

    // Stage 3 logic: truncate the scaled product toward zero and saturate.
    always_comb begin
        logic [63:0] p;
        logic [63:0] q;
        for (int i = 0; i < LANES; i++) begin
            p = prod2_reg[i][63] ? prod2_reg[i] + RND : prod2_reg[i];
            q = 64'($signed(p) >>> FRAC_BITS);
            if (!q[63] && (|q[62:31])) begin
                scale_next[i] = SAT_MAX;
            end else if (q[63] && !(&q[62:31])) begin
                scale_next[i] = SAT_MIN;
            end else begin
                scale_next[i] = q[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl3_reg  <= ctl2_reg;
            sum01_reg <= sq2_reg[0] + sq2_reg[1];
            sum23_reg <= sq2_reg[2] + sq2_reg[3];
            byp3_reg  <= (ctl2_reg.op == OP_SCALE) ? scale_next : byp2_reg;
            num3_reg  <= num2_reg;
            den3_reg  <= den2_reg;
        end
    end

    // Stage 4: the only carry out of the sum is the all-minimum vector.
    assign sum_next = {1'b0, sum01_reg} + {1'b0, sum23_reg};

    always_comb begin
        ctl4_next         = ctl3_reg;
        ctl4_next.len_sat = sum_next[64];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl4_reg         <= ctl4_next;
            sum4_reg         <= sum_next[63:0];
            byp4_reg         <= byp3_reg;
            num4_reg         <= num3_reg;
            den4_reg         <= den3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_ctl   = ctl4_reg;
    assign out_sum   = sum4_reg;
    assign out_num   = num4_reg;
    assign out_den   = den4_reg;
    assign out_byp   = byp4_reg;

endmodule

FILE: hw/rtl/v4a_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4a_sqrt: pipelined integer square root
// One result bit per stage over 32 stages; the rest of the item rides along.
// ----------------------------------------------------------------------------
module v4a_sqrt
    import v4a_pkg::*;
#(
    parameter int NW = 32 + FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  ctl_t          in_ctl,
    input  logic [63:0]   in_sum,
    input  logic [NW-1:0] in_num [LANES],
    input  logic [31:0]   in_den [LANES],
    input  logic [31:0]   in_byp [LANES],
    output logic          out_valid,
    output ctl_t          out_ctl,
    output logic [31:0]   out_len,
    output logic [NW-1:0] out_num [LANES],
    output logic [31:0]   out_den [LANES],
    output logic [31:0]   out_byp [LANES]
);

    localparam int LAST = SQRT_STAGES - 1;

    logic          v_reg    [SQRT_STAGES];
    ctl_t          ctl_reg  [SQRT_STAGES];
    logic [63:0]   rest_reg [SQRT_STAGES];
    logic [33:0]   rem_reg  [SQRT_STAGES];
    logic [31:0]   root_reg [SQRT_STAGES];
    logic [NW-1:0] num_reg  [SQRT_STAGES][LANES];
    logic [31:0]   den_reg  [SQRT_STAGES][LANES];
    logic [31:0]   byp_reg  [SQRT_STAGES][LANES];

    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        logic          v_in;
        ctl_t          ctl_in;
        logic [63:0]   rest_in;
        logic [33:0]   rem_in;
        logic [31:0]   root_in;
        logic [NW-1:0] num_in [LANES];
        logic [31:0]   den_in [LANES];
        logic [31:0]   byp_in [LANES];
        logic [35:0]   rem_sh;
        logic [35:0]   trial;

        if (g == 0) begin : g_first
            assign v_in    = in_valid;
            assign ctl_in  = in_ctl;
            assign rest_in = in_sum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign num_in  = in_num;
            assign den_in  = in_den;
            assign byp_in  = in_byp;
        end else begin : g_chain
            assign v_in    = v_reg[g-1];
            assign ctl_in  = ctl_reg[g-1];
            assign rest_in = rest_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign num_in  = num_reg[g-1];
            assign den_in  = den_reg[g-1];
            assign byp_in  = byp_reg[g-1];
        end

        // Bring down the next two bits and try root*4+1.
        assign rem_sh = {rem_in, rest_in[63:62]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ctl_reg[g]  <= ctl_in;
                rest_reg[g] <= {rest_in[61:0], 2'b00};
                num_reg[g]  <= num_in;
                den_reg[g]  <= den_in;
                byp_reg[g]  <= byp_in;
                if (rem_sh >= trial) begin
                    rem_reg[g]  <= 34'(rem_sh - trial);
                    root_reg[g] <= {root_in[30:0], 1'b1};
                end else begin
                    rem_reg[g]  <= rem_sh[33:0];
                    root_reg[g] <= {root_in[30:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[LAST];
    assign out_ctl   = ctl_reg[LAST];
    assign out_len   = ctl_reg[LAST].len_sat ? 32'hFFFF_FFFF : root_reg[LAST];
    assign out_num   = num_reg[LAST];
    assign out_den   = den_reg[LAST];
    assign out_byp   = byp_reg[LAST];

endmodule

FILE: hw/rtl/v4a_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v4a_div: four-lane pipelined divider with result formatting
// Checks for quotient overflow, runs a restoring division one quotient bit
// per stage, then applies sign, saturation and the bypass result.
// ----------------------------------------------------------------------------
module v4a_div
    import v4a_pkg::*;
#(
    parameter int NW = 32 + FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  ctl_t          in_ctl,
    input  logic [31:0]   in_len,
    input  logic [NW-1:0] in_num [LANES],
    input  logic [31:0]   in_den [LANES],
    input  logic [31:0]   in_byp [LANES],
    output logic          out_valid,
    output logic [31:0]   out_r [LANES],
    output logic [31:0]   out_len,
    output logic          out_err
);

    localparam int LAST = QUO_BITS - 1;

    // Prepare stage
    logic          pv_reg;
    ctl_t          pctl_reg;
    logic [31:0]   plen_reg;
    logic [3:0]    povf_reg;
    logic [NW-1:0] pnum_reg [LANES];
    logic [31:0]   pden_reg [LANES];
    logic [31:0]   pbyp_reg [LANES];
    logic [31:0]   prem_reg [LANES];

    // Quotient stages
    logic          v_reg   [QUO_BITS];
    ctl_t          ctl_reg [QUO_BITS];
    logic [31:0]   len_reg [QUO_BITS];
    logic [3:0]    ovf_reg [QUO_BITS];
    logic [NW-1:0] num_reg [QUO_BITS][LANES];
    logic [31:0]   den_reg [QUO_BITS][LANES];
    logic [31:0]   byp_reg [QUO_BITS][LANES];
    logic [31:0]   rem_reg [QUO_BITS][LANES];
    logic [30:0]   q_reg   [QUO_BITS][LANES];

    // Final stage
    logic          fv_reg;
    logic [31:0]   fr_reg [LANES];
    logic [31:0]   flen_reg;
    logic          ferr_reg;

    ctl_t          pctl_next;
    logic [31:0]   plen_next;
    logic [3:0]    povf_next;
    logic [31:0]   pden_next [LANES];
    logic [31:0]   prem_next [LANES];
    logic [31:0]   fr_next   [LANES];

    always_comb begin
        pctl_next = in_ctl;
        if ((in_ctl.op == OP_NORM) && (in_len == 32'd0)) begin
            pctl_next.use_div = 1'b0;
        end
        plen_next = ((in_ctl.op == OP_NORM) || (in_ctl.op == OP_MAG)) ? in_len : 32'd0;
        for (int i = 0; i < LANES; i++) begin
            pden_next[i] = (in_ctl.op == OP_NORM) ? in_len : in_den[i];
            // A quotient of 2^31 or more saturates whatever its sign.
            povf_next[i] = {{(64-NW){1'b0}}, in_num[i]} >= {1'b0, pden_next[i], 31'd0};
            prem_next[i] = 32'(in_num[i][NW-1:31]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pctl_reg <= pctl_next;
            plen_reg <= plen_next;
            povf_reg <= povf_next;
            pnum_reg <= in_num;
            pden_reg <= pden_next;
            pbyp_reg <= in_byp;
            prem_reg <= prem_next;
        end
    end

    for (genvar g = 0; g < QUO_BITS; g++) begin : g_stage
        localparam int BIT = QUO_BITS - 1 - g;

        logic          v_in;
        ctl_t          ctl_in;
        logic [31:0]   len_in;
        logic [3:0]    ovf_in;
        logic [NW-1:0] num_in [LANES];
        logic [31:0]   den_in [LANES];
        logic [31:0]   byp_in [LANES];
        logic [31:0]   rem_in [LANES];
        logic [30:0]   q_in   [LANES];

        if (g == 0) begin : g_first
            assign v_in   = pv_reg;
            assign ctl_in = pctl_reg;
            assign len_in = plen_reg;
            assign ovf_in = povf_reg;
            assign num_in = pnum_reg;
            assign den_in = pden_reg;
            assign byp_in = pbyp_reg;
            assign rem_in = prem_reg;
            for (genvar l = 0; l < LANES; l++) begin : g_q0
                assign q_in[l] = '0;
            end
        end else begin : g_chain
            assign v_in   = v_reg[g-1];
            assign ctl_in = ctl_reg[g-1];
            assign len_in = len_reg[g-1];
            assign ovf_in = ovf_reg[g-1];
            assign num_in = num_reg[g-1];
            assign den_in = den_reg[g-1];
            assign byp_in = byp_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign q_in   = q_reg[g-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            logic [32:0] rem_sh;
            if (en) begin
                ctl_reg[g] <= ctl_in;
                len_reg[g] <= len_in;
                ovf_reg[g] <= ovf_in;
                num_reg[g] <= num_in;
                den_reg[g] <= den_in;
                byp_reg[g] <= byp_in;
                for (int i = 0; i < LANES; i++) begin
                    rem_sh = {rem_in[i], num_in[i][BIT]};
                    if (rem_sh >= {1'b0, den_in[i]}) begin
                        rem_reg[g][i] <= 32'(rem_sh - {1'b0, den_in[i]});
                        q_reg[g][i]   <= {q_in[i][29:0], 1'b1};
                    end else begin
                        rem_reg[g][i] <= rem_sh[31:0];
                        q_reg[g][i]   <= {q_in[i][29:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (!ctl_reg[LAST].use_div) begin
                fr_next[i] = byp_reg[LAST][i];
            end else if (ovf_reg[LAST][i]) begin
                fr_next[i] = ctl_reg[LAST].neg[i] ? SAT_MIN : SAT_MAX;
            end else if (ctl_reg[LAST].neg[i]) begin
                fr_next[i] = 32'd0 - {1'b0, q_reg[LAST][i]};
            end else begin
                fr_next[i] = {1'b0, q_reg[LAST][i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (en) begin
            fv_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fr_reg   <= fr_next;
            flen_reg <= len_reg[LAST];
            ferr_reg <= ctl_reg[LAST].err;
        end
    end

    assign out_valid = fv_reg;
    assign out_r     = fr_reg;
    assign out_len   = flen_reg;
    assign out_err   = ferr_reg;

endmodule

FILE: hw/rtl/vec4_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_arith_unit: four-component Q16.16 vector arithmetic unit
// Add, subtract, scale, divide, scalar over vector, normalize and magnitude
// on signed fixed-point vectors, with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata (low bit first)                       tuser
//  s_        in   a_x a_y a_z a_w b_x b_y b_z b_w scalar      operation
//  m_        out  r_x r_y r_z r_w length                      error
//
// The unit accepts one item every cycle while the skid register is empty; each
// item passes through four operand stages, 32 square-root stages (one root bit each),
// one divider setup stage, 31 quotient stages (one bit each), one format
// stage and the output register. Every operation takes the same path, so
// results leave in the order their items arrived.
// Reset (aresetn low at a clock edge) empties every stage and the output.
// When the output is stalled, one more result is caught in a skid register
// and the whole pipeline then holds until the skid register drains.
// ----------------------------------------------------------------------------
module vec4_arith_unit
    import v4a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar
    input  logic [2:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // r_x, r_y, r_z, r_w, length
    output logic [0:0]   m_tuser    // error
);

    localparam int NW = 32 + FRAC_BITS;

    // Operands unpacked from the input bus.
    logic [31:0]   in_a [LANES];
    logic [31:0]   in_b [LANES];

    // Front end to square root.
    logic          fe_valid;
    ctl_t          fe_ctl;
    logic [63:0]   fe_sum;
    logic [NW-1:0] fe_num [LANES];
    logic [31:0]   fe_den [LANES];
    logic [31:0]   fe_byp [LANES];

    // Square root to divider.
    logic          sq_valid;
    ctl_t          sq_ctl;
    logic [31:0]   sq_len;
    logic [NW-1:0] sq_num [LANES];
    logic [31:0]   sq_den [LANES];
    logic [31:0]   sq_byp [LANES];

    // Finished results from the divider.
    logic          dv_valid;
    logic [31:0]   dv_r [LANES];
    logic [31:0]   dv_len;
    logic          dv_err;
    logic [159:0]  dv_data;

    // The whole pipeline moves whenever the skid register is empty.
    logic          pipe_en;

    logic          out_valid_reg, out_valid_next;
    logic [159:0]  out_data_reg, out_data_next;
    logic          out_err_reg, out_err_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [159:0]  skid_data_reg, skid_data_next;
    logic          skid_err_reg, skid_err_next;

    for (genvar l = 0; l < LANES; l++) begin : g_unpack
        assign in_a[l] = s_tdata[32*l +: 32];
        assign in_b[l] = s_tdata[128 + 32*l +: 32];
    end

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    v4a_front #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_a      (in_a),
        .in_b      (in_b),
        .in_s      (s_tdata[287:256]),
        .out_valid (fe_valid),
        .out_ctl   (fe_ctl),
        .out_sum   (fe_sum),
        .out_num   (fe_num),
        .out_den   (fe_den),
        .out_byp   (fe_byp)
    );

    v4a_sqrt #(
        .NW (NW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (fe_valid),
        .in_ctl    (fe_ctl),
        .in_sum    (fe_sum),
        .in_num    (fe_num),
        .in_den    (fe_den),
        .in_byp    (fe_byp),
        .out_valid (sq_valid),
        .out_ctl   (sq_ctl),
        .out_len   (sq_len),
        .out_num   (sq_num),
        .out_den   (sq_den),
        .out_byp   (sq_byp)
    );

    v4a_div #(
        .NW (NW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sq_valid),
        .in_ctl    (sq_ctl),
        .in_len    (sq_len),
        .in_num    (sq_num),
        .in_den    (sq_den),
        .in_byp    (sq_byp),
        .out_valid (dv_valid),
        .out_r     (dv_r),
        .out_len   (dv_len),
        .out_err   (dv_err)
    );

    assign dv_data = {dv_len, dv_r[3], dv_r[2], dv_r[1], dv_r[0]};

    // Output register with a one-entry skid. While the skid register is
    // empty the last divider stage hands its item on every cycle: into the
    // output register if that is free, otherwise into the skid register.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_err_next    = out_err_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_err_next   = skid_err_reg;
        if (!skid_valid_reg) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = dv_valid;
                out_data_next  = dv_data;
                out_err_next   = dv_err;
            end else if (dv_valid) begin
                skid_valid_next = 1'b1;
                skid_data_next  = dv_data;
                skid_err_next   = dv_err;
            end
        end else if (m_tready) begin
            out_data_next   = skid_data_reg;
            out_err_next    = skid_err_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_err_reg   <= out_err_next;
        skid_data_reg <= skid_data_next;
        skid_err_reg  <= skid_err_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_err_reg;

    // The skid register only ever holds an item behind a waiting output.
    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output is empty");

    // The skid register fills only when the output was stalled.
    a_skid_fill_on_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled without an output stall");

    // A divide by zero always comes with an all-zero vector and length.
    a_err_zero_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 160'd0))
        else $error("error flag set with a nonzero result");

endmodule
